@@ design/lsgt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsgt_pkg
// Shared codes, queue item layout and helpers for the lane split and gather
// tracker.
// ----------------------------------------------------------------------------
package lsgt_pkg;

    // input command codes
    localparam logic [1:0] CMD_REQ       = 2'd0;
    localparam logic [1:0] CMD_LOAD_RSP  = 2'd1;
    localparam logic [1:0] CMD_STORE_RSP = 2'd2;

    // result kind codes
    localparam logic [2:0] KIND_MEM_REQ    = 3'd0;
    localparam logic [2:0] KIND_REJECT     = 3'd1;
    localparam logic [2:0] KIND_LOAD_DONE  = 3'd2;
    localparam logic [2:0] KIND_STORE_DONE = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // what the back end does with a queue entry
    typedef enum logic [1:0] {
        Q_EMIT,
        Q_WRITE,
        Q_WRITE_RUN
    } q_op_t;

    // one queue entry: a ready result beat, or a data write plus optional run
    typedef struct packed {
        q_op_t       op;
        logic [2:0]  kind;
        logic        is_load;
        logic [63:0] address;
        logic [3:0]  size;
        logic [6:0]  tag;
        logic [7:0]  core;
        logic [3:0]  lane;
        logic [63:0] data;
        logic        last;
    } q_item_t;

    // keep only the low size bytes of a response word
    function automatic logic [63:0] cut_bytes(input logic [63:0] value,
                                              input logic [3:0] size);
        logic [63:0] mask;
        begin
            mask = (64'd1 << {size, 3'b000}) - 64'd1;
            if (size >= 4'd8)
                cut_bytes = value;
            else if (size == 4'd0)
                cut_bytes = 64'd0;
            else
                cut_bytes = value & mask;
        end
    endfunction

endpackage

@@ design/lane_split_gather_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_split_gather_tracker_core
// Vector memory request split and gather table, top level.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while its four-entry queue has room:
// request lanes become memory requests at once, load responses are trimmed
// and written into a gather RAM, and store or error results pass straight
// through. When a load slot completes, the back end plays its lanes out of
// the gather RAM lane by lane, with one RAM read and then one send for each
// lane, and no other queue entry leaves during that playback; input beats
// keep being taken during that time until the queue fills. A memory request
// carries tag slot*LANES+lane; responses must return that tag. cfg_data,
// written with cfg_we, is the core number stamped on every memory request.
module lane_split_gather_tracker_core #(
    parameter int SLOTS = 8,
    parameter int LANES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic        is_load,
    input  logic [3:0]  access_size,
    input  logic [63:0] lane_address,
    input  logic        last_lane,
    input  logic [6:0]  response_tag,
    input  logic [63:0] response_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic        request_is_load,
    output logic [63:0] out_address,
    output logic [3:0]  out_size,
    output logic [6:0]  out_tag,
    output logic [7:0]  out_core,
    output logic [3:0]  out_lane,
    output logic [63:0] out_data,
    output logic        last
);
    import lsgt_pkg::*;

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW  = $clog2(LANES + 1);
    localparam int MIW = (SLOTS * LANES > 1) ? $clog2(SLOTS * LANES) : 1;
    localparam int QW  = $bits(q_item_t) + MIW + CW;

    logic           push;
    logic           q_full;
    logic           q_empty;
    logic           pop;
    q_item_t        f_item;
    logic [MIW-1:0] f_base;
    logic [CW-1:0]  f_count;
    logic [QW-1:0]  q_head;
    q_item_t        b_item;
    logic [MIW-1:0] b_base;
    logic [CW-1:0]  b_count;

    // front: classify beats and keep slot table
    lsgt_front #(
        .SLOTS (SLOTS),
        .LANES (LANES),
        .SW    (SW),
        .LW    (LW),
        .CW    (CW),
        .MIW   (MIW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .is_load       (is_load),
        .access_size   (access_size),
        .lane_address  (lane_address),
        .last_lane     (last_lane),
        .response_tag  (response_tag),
        .response_data (response_data),
        .q_full        (q_full),
        .push          (push),
        .item          (f_item),
        .run_base      (f_base),
        .run_count     (f_count)
    );

    // decoupling queue
    lsgt_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_item, f_base, f_count}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    assign {b_item, b_base, b_count} = q_head;

    // back: results and gather playback
    lsgt_back #(
        .SLOTS (SLOTS),
        .LANES (LANES),
        .CW    (CW),
        .MIW   (MIW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_item          (b_item),
        .q_base          (b_base),
        .q_count         (b_count),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .request_is_load (request_is_load),
        .out_address     (out_address),
        .out_size        (out_size),
        .out_tag         (out_tag),
        .out_core        (out_core),
        .out_lane        (out_lane),
        .out_data        (out_data),
        .last            (last)
    );

endmodule

@@ design/lsgt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsgt_queue
// Small first-in first-out queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module lsgt_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    import lsgt_pkg::*;

    logic [W-1:0]             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W:0]     count_reg;

    assign full     = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ design/lsgt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsgt_front
// Accepts request lanes and responses, keeps the slot table and classifies
// each beat, making a queue entry for the back end where the beat yields one.
// ----------------------------------------------------------------------------
module lsgt_front #(
    parameter int SLOTS = 8,
    parameter int LANES = 16,
    parameter int SW    = 3,
    parameter int LW    = 4,
    parameter int CW    = 5,
    parameter int MIW   = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic                  is_load,
    input  logic [3:0]            access_size,
    input  logic [63:0]           lane_address,
    input  logic                  last_lane,
    input  logic [6:0]            response_tag,
    input  logic [63:0]           response_data,
    input  logic                  q_full,
    output logic                  push,
    output lsgt_pkg::q_item_t     item,
    output logic [MIW-1:0]        run_base,
    output logic [CW-1:0]         run_count
);
    import lsgt_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE,
        M_ISSUE,
        M_DROP
    } mode_t;

    mode_t           mode_reg;
    logic [SW-1:0]   open_slot_reg;
    logic [CW-1:0]   next_lane_reg;
    logic [7:0]      core_reg;

    logic            busy_reg   [SLOTS];
    logic            loads_reg  [SLOTS];
    logic [3:0]      size_reg   [SLOTS];
    logic [CW-1:0]   total_reg  [SLOTS];
    logic            closed_reg [SLOTS];
    logic [CW-1:0]   done_reg   [SLOTS];

    logic            accept;
    logic [3:0]      size_clamp;
    logic            free_found;
    logic [SW-1:0]   free_idx;
    logic [6:0]      div_tab [128];
    logic [LW-1:0]   mod_tab [128];
    logic [6:0]      r_slot7;
    logic [SW-1:0]   r_slot;
    logic [LW-1:0]   r_lane;
    logic            r_isld;
    logic            r_bad;
    logic            r_complete;
    logic [SW-1:0]   idx;
    logic            t_busy;
    logic            t_loads;
    logic [3:0]      t_size;
    logic [CW-1:0]   t_total;
    logic            t_closed;
    logic [CW-1:0]   t_done;
    logic [CW-1:0]   done_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    assign size_clamp = (access_size > 4'd8) ? 4'd8 : access_size;

    // constant tables splitting a tag into slot and lane
    for (genvar t = 0; t < 128; t++)
    begin : g_tag_tab
        assign div_tab[t] = 7'(t / LANES);
        assign mod_tab[t] = LW'(t % LANES);
    end

    assign r_slot7 = div_tab[response_tag];
    assign r_slot  = SW'(r_slot7);
    assign r_lane  = mod_tab[response_tag];
    assign r_isld  = (command == CMD_LOAD_RSP);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!busy_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = SW'(s);
            end
        end
    end

    // single table read port
    assign idx = (command != CMD_REQ) ? r_slot :
                 (mode_reg == M_IDLE) ? free_idx : open_slot_reg;

    assign t_busy   = busy_reg[idx];
    assign t_loads  = loads_reg[idx];
    assign t_size   = size_reg[idx];
    assign t_total  = total_reg[idx];
    assign t_closed = closed_reg[idx];
    assign t_done   = done_reg[idx];

    // response checks and completion
    assign r_bad = (r_slot7 >= 7'(SLOTS)) || !t_busy ||
                   (7'(r_lane) >= 7'(t_total)) || (t_loads != r_isld);
    assign done_inc   = (t_done < CW'(LANES)) ? t_done + CW'(1) : t_done;
    assign r_complete = t_closed && (done_inc >= t_total);

    // queue entry for this beat
    always_comb
    begin
        push      = 1'b0;
        item      = '0;
        item.op   = Q_EMIT;
        run_base  = MIW'(32'(r_slot) * LANES);
        run_count = t_total;
        unique case (command)
            CMD_REQ:
            begin
                unique case (mode_reg)
                    M_IDLE:
                    begin
                        push = accept;
                        item.is_load = is_load;
                        if (!free_found)
                            item.kind = KIND_REJECT;
                        else
                        begin
                            item.kind    = KIND_MEM_REQ;
                            item.address = lane_address;
                            item.size    = size_clamp;
                            item.tag     = 7'(32'(free_idx) * LANES);
                            item.core    = core_reg;
                            item.last    = last_lane;
                        end
                    end
                    M_ISSUE:
                    begin
                        push         = accept && (next_lane_reg < CW'(LANES));
                        item.kind    = KIND_MEM_REQ;
                        item.is_load = t_loads;
                        item.address = lane_address;
                        item.size    = t_size;
                        item.tag     = 7'(32'(open_slot_reg) * LANES + 32'(next_lane_reg));
                        item.core    = core_reg;
                        item.lane    = 4'(next_lane_reg);
                        item.last    = last_lane;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
            CMD_LOAD_RSP, CMD_STORE_RSP:
            begin
                if (r_bad)
                begin
                    push         = accept;
                    item.kind    = KIND_ERROR;
                    item.is_load = r_isld;
                    item.tag     = response_tag;
                end
                else if (r_isld)
                begin
                    push      = accept;
                    item.op   = r_complete ? Q_WRITE_RUN : Q_WRITE;
                    item.data = cut_bytes(response_data, t_size);
                    item.tag  = response_tag;
                    item.size = t_size;
                end
                else if (r_complete)
                begin
                    push      = accept;
                    item.kind = KIND_STORE_DONE;
                    item.size = t_size;
                    item.tag  = 7'(32'(r_slot) * LANES);
                    item.last = 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // open request state, slot table and core register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            open_slot_reg <= '0;
            next_lane_reg <= '0;
            core_reg      <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                busy_reg[s]   <= 1'b0;
                loads_reg[s]  <= 1'b0;
                size_reg[s]   <= '0;
                total_reg[s]  <= '0;
                closed_reg[s] <= 1'b0;
                done_reg[s]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                core_reg <= cfg_data;
            if (accept)
            begin
                if (command == CMD_REQ)
                begin
                    unique case (mode_reg)
                        M_IDLE:
                        begin
                            if (!free_found)
                                mode_reg <= last_lane ? M_IDLE : M_DROP;
                            else
                            begin
                                busy_reg[free_idx]   <= 1'b1;
                                loads_reg[free_idx]  <= is_load;
                                size_reg[free_idx]   <= size_clamp;
                                total_reg[free_idx]  <= CW'(1);
                                closed_reg[free_idx] <= last_lane;
                                done_reg[free_idx]   <= '0;
                                open_slot_reg        <= free_idx;
                                next_lane_reg        <= CW'(1);
                                mode_reg             <= last_lane ? M_IDLE : M_ISSUE;
                            end
                        end
                        M_ISSUE:
                        begin
                            if (next_lane_reg < CW'(LANES))
                            begin
                                next_lane_reg            <= next_lane_reg + CW'(1);
                                total_reg[open_slot_reg] <= next_lane_reg + CW'(1);
                            end
                            if (last_lane)
                            begin
                                closed_reg[open_slot_reg] <= 1'b1;
                                mode_reg                  <= M_IDLE;
                            end
                        end
                        default:
                        begin
                            if (last_lane)
                                mode_reg <= M_IDLE;
                        end
                    endcase
                end
                else if ((command == CMD_LOAD_RSP || command == CMD_STORE_RSP) && !r_bad)
                begin
                    done_reg[r_slot] <= done_inc;
                    if (r_complete)
                        busy_reg[r_slot] <= 1'b0;
                end
            end
        end
    end

endmodule

@@ design/lsgt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsgt_back
// Drains the queue: sends ready result beats, writes gathered load data and
// plays out load completion runs from the gather memory.
// ----------------------------------------------------------------------------
module lsgt_back #(
    parameter int SLOTS = 8,
    parameter int LANES = 16,
    parameter int CW    = 5,
    parameter int MIW   = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  lsgt_pkg::q_item_t    q_item,
    input  logic [MIW-1:0]       q_base,
    input  logic [CW-1:0]        q_count,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           kind,
    output logic                 request_is_load,
    output logic [63:0]          out_address,
    output logic [3:0]           out_size,
    output logic [6:0]           out_tag,
    output logic [7:0]           out_core,
    output logic [3:0]           out_lane,
    output logic [63:0]          out_data,
    output logic                 last
);
    import lsgt_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } state_t;

    state_t          state_reg;
    logic [MIW-1:0]  base_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   k_reg;
    logic [3:0]      size_reg;
    logic [63:0]     rd_data_reg;
    logic [63:0]     gather_mem [SLOTS * LANES];

    logic            out_valid_reg;
    q_item_t         out_reg;

    logic            can_load;
    logic            send_now;
    logic [MIW-1:0]  rd_idx;
    logic            mem_we;

    assign can_load = !out_valid_reg || out_ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty &&
                      ((q_item.op != Q_EMIT) || can_load);
    assign mem_we   = pop && (q_item.op != Q_EMIT);
    assign rd_idx   = base_reg + MIW'(k_reg);

    // a new beat enters the output register this cycle
    assign send_now = (pop && (q_item.op == Q_EMIT)) ||
                      ((state_reg == B_SEND) && can_load);

    // gather memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            gather_mem[MIW'(q_item.tag)] <= q_item.data;
        if (state_reg == B_READ)
            rd_data_reg <= gather_mem[rd_idx];
    end

    // run sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            size_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_ready && !send_now)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (q_item.op)
                            Q_EMIT:
                            begin
                                out_reg       <= q_item;
                                out_valid_reg <= 1'b1;
                            end
                            Q_WRITE_RUN:
                            begin
                                base_reg  <= q_base;
                                count_reg <= q_count;
                                size_reg  <= q_item.size;
                                k_reg     <= '0;
                                state_reg <= B_READ;
                            end
                            default:
                            begin
                                state_reg <= B_IDLE;
                            end
                        endcase
                    end
                end
                B_READ:
                begin
                    state_reg <= B_SEND;
                end
                default:
                begin
                    if (can_load)
                    begin
                        out_reg.op      <= Q_EMIT;
                        out_reg.kind    <= KIND_LOAD_DONE;
                        out_reg.is_load <= 1'b1;
                        out_reg.address <= '0;
                        out_reg.size    <= size_reg;
                        out_reg.tag     <= 7'(rd_idx);
                        out_reg.core    <= '0;
                        out_reg.lane    <= 4'(k_reg);
                        out_reg.data    <= rd_data_reg;
                        out_reg.last    <= (k_reg + CW'(1) == count_reg);
                        out_valid_reg   <= 1'b1;
                        k_reg           <= k_reg + CW'(1);
                        state_reg       <= (k_reg + CW'(1) == count_reg) ? B_IDLE : B_READ;
                    end
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign request_is_load = out_reg.is_load;
    assign out_address     = out_reg.address;
    assign out_size        = out_reg.size;
    assign out_tag         = out_reg.tag;
    assign out_core        = out_reg.core;
    assign out_lane        = out_reg.lane;
    assign out_data        = out_reg.data;
    assign last            = out_reg.last;

endmodule
